// ===== rtl/core/cmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmc_pkg
// shared widths, reset values, register codes and types of the colour match
// centroid tracker
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int ColW     = 8;
  localparam int CoordW   = 10;
  localparam int ThrW     = 11;
  localparam int DistW    = 22;
  localparam int CntW     = 21;
  localparam int SumW     = 30;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;
  localparam int InDataW  = 48;
  localparam int OutDataW = 48;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int CoordMax = (1 << CoordW) - 1;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;

  localparam logic [ColW-1:0] RstRed   = 8'd255;
  localparam logic [ColW-1:0] RstGreen = 8'd182;
  localparam logic [ColW-1:0] RstBlue  = 8'd193;
  localparam logic [ThrW-1:0] RstThr   = 11'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2,
    CFG_THR   = 2'd3
  } cfg_idx_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic              hit;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
  } qent_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

// ===== rtl/core/color_match_centroid.sv =====
// ----------------------------------------------------------------------------
// color_match_centroid
// colour threshold centroid tracker: counts pixels close to a target colour
// and reports their mean position at the end of each frame
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_*     sink       one pixel: colour, position, end of frame on tlast
//  out_*    source     one result per frame: centroid and count, found on tuser
//  cfg_*    sink       target colour and distance threshold, write only
//
//  pixels are taken one per cycle while in_tready is high; the front pipeline
//  and a four-entry queue sit before the accumulators
//  the last pixel of a frame holds the back while it loads the divider, runs
//  30 divide steps and hands off, so a new frame stalls once the queue fills
//  an untaken result only holds the next frame's hand-off; in_tready drops
//  when the queue fills behind it
//  rst_n is synchronous; it clears sums and valid flags and reloads the
//  default colour 255/182/193 and threshold 2.5
// ----------------------------------------------------------------------------
module color_match_centroid #(
  parameter int MAX_WIDTH  = cmc_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = cmc_pkg::DefMaxHeight
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wen,
  input  logic [cmc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cmc_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16], pixel_x[33:24],
  // pixel_y[43:34], zero[47:44]
  input  logic [cmc_pkg::InDataW-1:0]   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // centroid_x[9:0], centroid_y[19:10], match_total[40:20], zero[47:41]
  output logic [cmc_pkg::OutDataW-1:0]  out_tdata,
  // found[0]
  output logic                          out_tuser
);
  import cmc_pkg::*;

  qent_t push_ent, head;
  logic  q_push, q_pop, q_empty, q_full;

  cmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ent     (push_ent)
  );

  cmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (push_ent),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  cmc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/cmc_front.sv =====
// ----------------------------------------------------------------------------
// cmc_front
// colour registers and two-stage distance pipeline that marks each pixel as
// hit or miss and pushes it into the queue
// ----------------------------------------------------------------------------
module cmc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wen,
  input  logic [cmc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cmc_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [cmc_pkg::InDataW-1:0]  in_tdata,
  input  logic                         in_tlast,
  input  logic                         q_full,
  output logic                         q_push,
  output cmc_pkg::qent_t               q_ent
);
  import cmc_pkg::*;

  logic [ColW-1:0]   tgt_r_r, tgt_g_r, tgt_b_r;
  logic [ThrW-1:0]   thr_r;
  logic [DistW-1:0]  thr2_r;

  logic              s1_vld_r;
  logic [ColW-1:0]   s1_dr_r, s1_dg_r, s1_db_r;
  logic [CoordW-1:0] s1_x_r, s1_y_r;
  logic              s1_last_r;

  logic              s2_vld_r;
  logic [DistW-1:0]  s2_dist_r;
  logic [CoordW-1:0] s2_x_r, s2_y_r;
  logic              s2_last_r;

  logic              adv;
  logic [ColW-1:0]   px_r, px_g, px_b;
  logic [ColW-1:0]   dr_nxt, dg_nxt, db_nxt;
  logic [2*ColW-1:0] sq_r, sq_g, sq_b;
  logic [DistW-1:0]  dist_nxt;

  function automatic logic [ColW-1:0] abs_diff(input logic [ColW-1:0] a,
                                               input logic [ColW-1:0] b);
    abs_diff = (a >= b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r_r <= RstRed;
      tgt_g_r <= RstGreen;
      tgt_b_r <= RstBlue;
      thr_r   <= RstThr;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RED:   tgt_r_r <= cfg_wdata[ColW-1:0];
        CFG_GREEN: tgt_g_r <= cfg_wdata[ColW-1:0];
        CFG_BLUE:  tgt_b_r <= cfg_wdata[ColW-1:0];
        CFG_THR:   thr_r   <= cfg_wdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // squared threshold, registered in the cycle after the threshold register
  always_ff @(posedge clk) begin
    thr2_r <= {{(DistW-ThrW){1'b0}}, thr_r} * {{(DistW-ThrW){1'b0}}, thr_r};
  end

  assign px_r = in_tdata[ColW-1:0];
  assign px_g = in_tdata[2*ColW-1:ColW];
  assign px_b = in_tdata[3*ColW-1:2*ColW];

  assign dr_nxt = abs_diff(px_r, tgt_r_r);
  assign dg_nxt = abs_diff(px_g, tgt_g_r);
  assign db_nxt = abs_diff(px_b, tgt_b_r);

  assign sq_r = {{ColW{1'b0}}, s1_dr_r} * {{ColW{1'b0}}, s1_dr_r};
  assign sq_g = {{ColW{1'b0}}, s1_dg_r} * {{ColW{1'b0}}, s1_dg_r};
  assign sq_b = {{ColW{1'b0}}, s1_db_r} * {{ColW{1'b0}}, s1_db_r};

  // 16 * (dr^2 + dg^2 + db^2)
  assign dist_nxt = {DistW'({2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b})} << 4;

  // pipeline moves unless the last stage is blocked by a full queue
  assign adv       = !(s2_vld_r && q_full);
  assign in_tready = adv;
  assign q_push    = s2_vld_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dr_r   <= dr_nxt;
      s1_dg_r   <= dg_nxt;
      s1_db_r   <= db_nxt;
      s1_x_r    <= in_tdata[3*ColW+CoordW-1:3*ColW];
      s1_y_r    <= in_tdata[3*ColW+2*CoordW-1:3*ColW+CoordW];
      s1_last_r <= in_tlast;
      s2_dist_r <= dist_nxt;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    q_ent.hit  = s2_dist_r < thr2_r;
    q_ent.x    = s2_x_r;
    q_ent.y    = s2_y_r;
    q_ent.last = s2_last_r;
  end

endmodule

// ===== rtl/core/cmc_queue.sv =====
// ----------------------------------------------------------------------------
// cmc_queue
// small fifo of classified pixels between the front and the back
// ----------------------------------------------------------------------------
module cmc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cmc_pkg::qent_t push_ent,
  input  logic           pop,
  output cmc_pkg::qent_t head,
  output logic           empty,
  output logic           full
);
  import cmc_pkg::*;

  qent_t            ent_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]   cnt_r;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (QPtrW+1)'(QDepth));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_ent;
  end

endmodule

// ===== rtl/core/cmc_back.sv =====
// ----------------------------------------------------------------------------
// cmc_back
// frame accumulators, shared-divisor restoring divider for both means and
// the result register
// ----------------------------------------------------------------------------
module cmc_back #(
  parameter int MAX_WIDTH  = cmc_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = cmc_pkg::DefMaxHeight
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmc_pkg::qent_t                head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cmc_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tuser
);
  import cmc_pkg::*;

  localparam int LimX = (MAX_WIDTH - 1 < CoordMax) ? MAX_WIDTH - 1 : CoordMax;
  localparam int LimY = (MAX_HEIGHT - 1 < CoordMax) ? MAX_HEIGHT - 1 : CoordMax;

  bk_state_t state_r, state_nxt;

  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [SumW-1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SumW:0]      sx_add, sy_add;

  logic [SumW-1:0]    qx_r, qy_r;
  logic [CntW-1:0]    rx_r, ry_r;
  logic [CntW-1:0]    dvs_r;
  logic [DivCntW-1:0] step_r;
  logic [CntW:0]      tx, ty;
  logic               gex, gey;

  logic               out_vld_r;
  logic               found_r;
  logic [CoordW-1:0]  cx_r, cy_r;
  logic [CntW-1:0]    tot_r;

  logic               take_last, div_en, out_free, load_out;

  // accumulate the head pixel, saturating
  assign sx_add = {1'b0, sx_r} + (SumW+1)'(head.x);
  assign sy_add = {1'b0, sy_r} + (SumW+1)'(head.y);

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    if (head.hit) begin
      if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
      sx_nxt = sx_add[SumW] ? '1 : sx_add[SumW-1:0];
      sy_nxt = sy_add[SumW] ? '1 : sy_add[SumW-1:0];
    end
  end

  assign out_free  = !out_vld_r || out_tready;
  assign take_last = pop && head.last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_ACC:  if (take_last) state_nxt = BK_DIV;
      BK_DIV:  if (step_r == DivCntW'(DivSteps - 1)) state_nxt = BK_DONE;
      BK_DONE: if (out_free) state_nxt = BK_ACC;
      default: state_nxt = BK_ACC;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_ACC:  pop      = !empty;
      BK_DIV:  div_en   = 1'b1;
      BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_ACC;
      cnt_r   <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (take_last) begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
      end else if (pop) begin
        cnt_r <= cnt_nxt;
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
      end
      if (div_en) step_r <= step_r + 1'b1;
      else        step_r <= '0;
    end
  end

  // one quotient bit per cycle for x and y together
  assign tx  = {rx_r, qx_r[SumW-1]};
  assign ty  = {ry_r, qy_r[SumW-1]};
  assign gex = tx >= {1'b0, dvs_r};
  assign gey = ty >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (take_last) begin
      qx_r  <= sx_nxt;
      qy_r  <= sy_nxt;
      rx_r  <= '0;
      ry_r  <= '0;
      dvs_r <= cnt_nxt;
    end else if (div_en) begin
      qx_r <= {qx_r[SumW-2:0], gex};
      qy_r <= {qy_r[SumW-2:0], gey};
      rx_r <= gex ? CntW'(tx - {1'b0, dvs_r}) : tx[CntW-1:0];
      ry_r <= gey ? CntW'(ty - {1'b0, dvs_r}) : ty[CntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found_r <= (dvs_r != '0);
      tot_r   <= dvs_r;
      // empty frame gives zero, otherwise clamp the mean to the frame
      if (dvs_r == '0)                cx_r <= '0;
      else if (qx_r > SumW'(LimX))    cx_r <= CoordW'(LimX);
      else                            cx_r <= qx_r[CoordW-1:0];
      if (dvs_r == '0)                cy_r <= '0;
      else if (qy_r > SumW'(LimY))    cy_r <= CoordW'(LimY);
      else                            cy_r <= qy_r[CoordW-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = found_r;
  assign out_tdata  = {{(OutDataW-2*CoordW-CntW){1'b0}}, tot_r, cy_r, cx_r};

endmodule
